// ===== hdl/akf_pkg.sv =====
// Shared types, constants and saturation helpers for the angle Kalman filter.
// No dependencies.
package akf_pkg;

    localparam int W_MEAS  = 25;
    localparam int W_RATE  = 32;
    localparam int W_DT    = 16;
    localparam int W_NOISE = 24;
    localparam int W_ANG   = 32;
    localparam int W_COV   = 48;
    localparam int W_K     = 32;
    localparam int W_MX    = 31;
    localparam int W_MY    = 50;
    localparam int W_ACC   = W_MX + W_MY;
    localparam int W_PROD  = 62;
    localparam int W_DEN   = 49;
    localparam int W_REM   = 50;
    localparam int W_QUO   = 31;
    localparam int W_CNT   = 5;
    localparam logic [W_CNT-1:0] CNT_LAST = W_CNT'(W_MX - 1);

    localparam logic [1:0] REG_ANGLE_Q = 2'd0;
    localparam logic [1:0] REG_BIAS_Q  = 2'd1;
    localparam logic [1:0] REG_MEAS_R  = 2'd2;

    localparam logic [W_NOISE-1:0] RST_ANGLE_Q = 24'd16777;
    localparam logic [W_NOISE-1:0] RST_BIAS_Q  = 24'd50332;
    localparam logic [W_NOISE-1:0] RST_MEAS_R  = 24'd503316;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANG,
        ST_T,
        ST_P00,
        ST_P11,
        ST_K0,
        ST_K1,
        ST_UPD_A,
        ST_UPD_B,
        ST_C00,
        ST_C01,
        ST_C10,
        ST_C11,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_LOAD,
        PH_RUN,
        PH_ROUND,
        PH_WB
    } t_phase;

    typedef enum logic [1:0] {
        SH_8,
        SH_16,
        SH_30
    } t_shift;

    function automatic logic signed [W_ANG-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi[W_ANG-1:0];
        end else if (v < lo) begin
            return lo[W_ANG-1:0];
        end
        return v[W_ANG-1:0];
    endfunction

    function automatic logic signed [W_COV-1:0] sat48(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_7FFF_FFFF_FFFF;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi[W_COV-1:0];
        end else if (v < lo) begin
            return lo[W_COV-1:0];
        end
        return v[W_COV-1:0];
    endfunction

endpackage

// ===== hdl/angle_kalman_filter_core.sv =====
// Angle Kalman filter: sequencer, bit-serial multiplier and restoring divider. Uses akf_pkg.
// From request accept to result valid the sequencer runs 10 multiplies, 2 divides and an
// output step; one request in flight, so a new request is taken only after the last result
// is loaded. A result held by the receiver stalls the output load and o_ready with it.
// Each multiply retires one multiplier bit per cycle, each divide one quotient bit.
// Reset (synchronous, active low): estimates, covariance zero, noise at defaults, no result.
module angle_kalman_filter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [akf_pkg::W_MEAS-1:0] i_measured_angle,
    input  logic signed [akf_pkg::W_RATE-1:0] i_gyro_rate,
    input  logic [akf_pkg::W_DT-1:0]      i_time_step,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [akf_pkg::W_ANG-1:0] o_filtered_angle,
    output logic signed [akf_pkg::W_ANG-1:0] o_bias_estimate,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import akf_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [W_CNT-1:0] r_cnt;

    logic [W_NOISE-1:0] r_apn, r_bpn, r_mn;
    logic signed [W_ANG-1:0] r_angle, r_bias;
    logic signed [W_COV-1:0] r_cov [4];
    logic r_out_valid;
    logic signed [W_ANG-1:0] r_out_angle, r_out_bias;

    logic signed [W_MEAS-1:0] r_meas;
    logic signed [W_RATE-1:0] r_gyro;
    logic [W_DT-1:0] r_dt;
    logic signed [W_COV-1:0] r_q00, r_q01, r_q10, r_q11;
    logic signed [W_COV:0] r_t;
    logic signed [W_ANG-1:0] r_ang;
    logic signed [W_K-1:0] r_k0, r_k1;

    logic [W_MX-1:0] r_mx;
    logic [W_MY-1:0] r_my;
    logic [W_ACC-1:0] r_acc;
    logic r_mneg;
    logic signed [W_PROD-1:0] r_prod;

    logic [W_DEN-1:0] r_den;
    logic r_den_neg;
    logic [W_REM-1:0] r_rem;
    logic [W_QUO-1:0] r_quo;
    logic r_dneg, r_dzero, r_dsat;

    logic is_div, out_load, cfg_wr;
    t_state op_next;
    t_shift sh;
    logic signed [32:0] xsrc, xmag;
    logic signed [51:0] ysrc, ymag;
    logic signed [51:0] rate, inner, innov;
    logic [W_MY:0] mstep;
    logic [W_ACC:0] rnd, shd;
    logic [60:0] pmag;
    logic signed [W_PROD-1:0] prod;
    logic signed [W_COV-1:0] nsrc;
    logic [W_COV-1:0] nmag;
    logic [W_REM-1:0] dsub;
    logic dge;
    logic [W_QUO-1:0] fq;
    logic signed [W_K-1:0] kval;
    logic signed [W_COV+1:0] ssum;
    logic signed [63:0] wsum0, wsum1, wsum2;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign o_valid = r_out_valid;
    assign o_filtered_angle = r_out_angle;
    assign o_bias_estimate = r_out_bias;

    always_comb begin
        unique case (paddr[3:2])
            REG_ANGLE_Q: prdata = {8'b0, r_apn};
            REG_BIAS_Q:  prdata = {8'b0, r_bpn};
            REG_MEAS_R:  prdata = {8'b0, r_mn};
            default:     prdata = 32'b0;
        endcase
    end

    // operation order
    always_comb begin
        unique case (r_state)
            ST_ANG:   op_next = ST_T;
            ST_T:     op_next = ST_P00;
            ST_P00:   op_next = ST_P11;
            ST_P11:   op_next = ST_K0;
            ST_K0:    op_next = ST_K1;
            ST_K1:    op_next = ST_UPD_A;
            ST_UPD_A: op_next = ST_UPD_B;
            ST_UPD_B: op_next = ST_C00;
            ST_C00:   op_next = ST_C01;
            ST_C01:   op_next = ST_C10;
            ST_C10:   op_next = ST_C11;
            ST_C11:   op_next = ST_OUT;
            default:  op_next = ST_IDLE;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_ANG;
                    n_phase = PH_LOAD;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                unique case (r_phase)
                    PH_LOAD: n_phase = PH_RUN;
                    PH_RUN: begin
                        if (r_cnt == CNT_LAST) begin
                            n_phase = is_div ? PH_WB : PH_ROUND;
                        end
                    end
                    PH_ROUND: n_phase = PH_WB;
                    PH_WB: begin
                        n_phase = PH_LOAD;
                        n_state = op_next;
                    end
                    default: n_phase = PH_LOAD;
                endcase
            end
        endcase
    end

    // control outputs
    always_comb begin
        o_ready  = (r_state == ST_IDLE);
        is_div   = (r_state == ST_K0) || (r_state == ST_K1);
        out_load = (r_state == ST_OUT) && (!r_out_valid || i_ready);
        unique case (r_state)
            ST_ANG, ST_T, ST_P00: sh = SH_16;
            ST_P11:               sh = SH_8;
            default:              sh = SH_30;
        endcase
    end

    // multiplier operands
    always_comb begin
        rate  = 52'(r_gyro) - 52'(r_bias);
        inner = 52'(r_t) - 52'(r_q01) - 52'(r_q10) + $signed({20'b0, r_apn, 8'b0});
        innov = 52'(r_meas) - 52'(r_ang);
        xsrc = 33'sd0;
        ysrc = 52'sd0;
        unique case (r_state)
            ST_ANG: begin
                xsrc = $signed({17'b0, r_dt});
                ysrc = rate;
            end
            ST_T: begin
                xsrc = $signed({17'b0, r_dt});
                ysrc = 52'(r_q11);
            end
            ST_P00: begin
                xsrc = $signed({17'b0, r_dt});
                ysrc = inner;
            end
            ST_P11: begin
                xsrc = $signed({17'b0, r_dt});
                ysrc = $signed({28'b0, r_bpn});
            end
            ST_UPD_A: begin
                xsrc = 33'(r_k0);
                ysrc = innov;
            end
            ST_UPD_B: begin
                xsrc = 33'(r_k1);
                ysrc = innov;
            end
            ST_C00: begin
                xsrc = 33'(r_k0);
                ysrc = 52'(r_q00);
            end
            ST_C01: begin
                xsrc = 33'(r_k0);
                ysrc = 52'(r_q01);
            end
            ST_C10: begin
                xsrc = 33'(r_k1);
                ysrc = 52'(r_q00);
            end
            ST_C11: begin
                xsrc = 33'(r_k1);
                ysrc = 52'(r_q01);
            end
            default: begin
                xsrc = 33'sd0;
                ysrc = 52'sd0;
            end
        endcase
        xmag = xsrc[32] ? -xsrc : xsrc;
        ymag = ysrc[51] ? -ysrc : ysrc;
    end

    // multiplier step, rounding and clamp
    always_comb begin
        mstep = {1'b0, r_acc[W_ACC-1:W_MX]} + (r_mx[0] ? {1'b0, r_my} : '0);
        case (sh)
            SH_8: begin
                rnd = {1'b0, r_acc} + (W_ACC+1)'(128);
                shd = rnd >> 8;
            end
            SH_16: begin
                rnd = {1'b0, r_acc} + (W_ACC+1)'(32768);
                shd = rnd >> 16;
            end
            default: begin
                rnd = {1'b0, r_acc} + (W_ACC+1)'(536870912);
                shd = rnd >> 30;
            end
        endcase
        pmag = (shd > ((W_ACC+1)'(1) << 60)) ? (61'(1) << 60) : shd[60:0];
        prod = r_mneg ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
    end

    // divider, gain sign and update sums
    always_comb begin
        nsrc = (r_state == ST_K1) ? r_q10 : r_q00;
        nmag = nsrc[W_COV-1] ? W_COV'(-nsrc) : W_COV'(nsrc);
        dge  = r_rem >= {1'b0, r_den};
        dsub = r_rem - {1'b0, r_den};
        if (r_dzero) begin
            fq = '0;
        end else if (r_dsat) begin
            fq = '1;
        end else begin
            fq = r_quo;
        end
        kval = r_dneg ? -$signed({1'b0, fq}) : $signed({1'b0, fq});
        ssum = (W_COV+2)'(r_q00) + $signed({18'b0, r_mn, 8'b0});
        wsum0 = 64'(r_angle) + 64'(r_prod);
        wsum1 = 64'(r_q00) + 64'(r_prod);
        wsum2 = 64'(r_q11) + 64'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_LOAD;
            r_out_valid <= 1'b0;
            r_apn       <= RST_ANGLE_Q;
            r_bpn       <= RST_BIAS_Q;
            r_mn        <= RST_MEAS_R;
            r_angle     <= '0;
            r_bias      <= '0;
            r_cov[0]    <= '0;
            r_cov[1]    <= '0;
            r_cov[2]    <= '0;
            r_cov[3]    <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_ANGLE_Q: r_apn <= pwdata[W_NOISE-1:0];
                    REG_BIAS_Q:  r_bpn <= pwdata[W_NOISE-1:0];
                    REG_MEAS_R:  r_mn  <= pwdata[W_NOISE-1:0];
                    default:     ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_phase == PH_WB) begin
                case (r_state)
                    ST_UPD_A: r_angle  <= sat32(64'(r_ang) + 64'(r_prod));
                    ST_UPD_B: r_bias   <= sat32(64'(r_bias) + 64'(r_prod));
                    ST_C00:   r_cov[0] <= sat48(64'(r_q00) - 64'(r_prod));
                    ST_C01:   r_cov[1] <= sat48(64'(r_q01) - 64'(r_prod));
                    ST_C10:   r_cov[2] <= sat48(64'(r_q10) - 64'(r_prod));
                    ST_C11:   r_cov[3] <= sat48(64'(r_q11) - 64'(r_prod));
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_angle <= r_angle;
            r_out_bias  <= r_bias;
        end
        if (o_ready && i_valid) begin
            r_meas <= i_measured_angle;
            r_gyro <= i_gyro_rate;
            r_dt   <= i_time_step;
            r_q00  <= r_cov[0];
            r_q01  <= r_cov[1];
            r_q10  <= r_cov[2];
            r_q11  <= r_cov[3];
        end
        if (r_state != ST_IDLE && r_state != ST_OUT) begin
            case (r_phase)
                PH_LOAD: begin
                    r_cnt  <= '0;
                    r_mx   <= xmag[W_MX-1:0];
                    r_my   <= ymag[W_MY-1:0];
                    r_mneg <= xsrc[32] ^ ysrc[51];
                    r_acc  <= '0;
                    r_rem  <= {2'b0, nmag};
                    r_quo  <= '0;
                    r_dneg <= nsrc[W_COV-1] ^ r_den_neg;
                    r_dzero <= (r_den == '0);
                    r_dsat <= {2'b0, nmag} >= {r_den, 1'b0};
                end
                PH_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_acc <= {mstep, r_acc[W_MX-1:1]};
                    r_mx  <= r_mx >> 1;
                    r_rem <= {(dge ? dsub[W_REM-2:0] : r_rem[W_REM-2:0]), 1'b0};
                    r_quo <= {r_quo[W_QUO-2:0], dge};
                end
                PH_ROUND: begin
                    r_prod <= prod;
                end
                default: begin
                    case (r_state)
                        ST_ANG: r_ang <= sat32(wsum0);
                        ST_T:   r_t   <= r_prod[W_COV:0];
                        ST_P00: r_q00 <= sat48(wsum1);
                        ST_P11: begin
                            r_q11     <= sat48(wsum2);
                            r_q01     <= sat48(64'(r_q01) - 64'(r_t));
                            r_q10     <= sat48(64'(r_q10) - 64'(r_t));
                            r_den     <= ssum[W_COV+1] ? W_DEN'(-ssum) : W_DEN'(ssum);
                            r_den_neg <= ssum[W_COV+1];
                        end
                        ST_K0:  r_k0 <= kval;
                        ST_K1:  r_k1 <= kval;
                        default: ;
                    endcase
                end
            endcase
        end
    end

endmodule

// ===== hdl/akf_checker.sv =====
// Port-level checks for angle_kalman_filter_core, bound into that module.
// No package dependencies.
module akf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_filtered_angle,
    input logic [31:0] o_bias_estimate
);

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request accepted while busy");

    a_no_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_ready |=> !o_valid)
        else $error("result appeared without work");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_filtered_angle)
            && $stable(o_bias_estimate))
        else $error("stalled result changed");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("reset did not clear pipeline");

endmodule

bind angle_kalman_filter_core akf_checker u_akf_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for angle_kalman_filter_core: random and directed sensor requests,
// a fixed-point predictor of the filter, APB noise register writes, random stalls.
// Depends on akf_pkg and the angle_kalman_filter_core RTL.
module testbench;
    import akf_pkg::*;

    typedef struct {
        logic signed [W_MEAS-1:0] meas;
        logic signed [W_RATE-1:0] rate;
        logic [W_DT-1:0]          dt;
    } t_sample;

    typedef struct {
        logic signed [W_ANG-1:0] ang;
        logic signed [W_ANG-1:0] bias;
    } t_estimate;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic signed [W_MEAS-1:0] i_measured_angle = '0;
    logic signed [W_RATE-1:0] i_gyro_rate = '0;
    logic [W_DT-1:0]          i_time_step = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [W_ANG-1:0]  o_filtered_angle;
    logic signed [W_ANG-1:0]  o_bias_estimate;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [3:0]               paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    angle_kalman_filter_core dut (.*);

    always #1 i_clk = ~i_clk;

    t_sample   pending_samples[$];
    t_estimate expected_estimates[$];
    int        mismatches = 0;
    int        results_seen = 0;
    int        samples_sent = 0;
    bit        tx_quiet = 0;
    bit        rx_quiet = 0;
    bit        rx_long_stall_req = 0;

    // predictor state
    logic [W_NOISE-1:0] q_angle, q_bias, r_meas;
    longint             est_angle, est_bias;
    longint             cov[4];

    function automatic longint sat_to(longint v, int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // (a*b) >> sh, rounded half away from zero, magnitude clamped to 2^60
    function automatic longint mul_round(longint a, longint b, int sh);
        logic [127:0] p;
        logic [63:0]  x, y;
        longint       m;
        x = a < 0 ? -a : a;
        y = b < 0 ? -b : b;
        p = {64'd0, x} * {64'd0, y};
        p = p + (128'd1 << (sh - 1));
        p = p >> sh;
        if (p > (128'd1 << 60))
            p = 128'd1 << 60;
        m = longint'(p[63:0]);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    // Q1.30 gain num/den, truncated, saturated, zero when den is zero
    function automatic longint kalman_gain(longint num, longint den);
        logic [63:0] n, d, q, r, f;
        if (den == 0)
            return 0;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = n / d;
        r = n % d;
        if (q >= 2) begin
            f = 64'h7FFF_FFFF;
        end else begin
            f = q;
            for (int i = 0; i < 30; i++) begin
                r = r << 1;
                f = f << 1;
                if (r >= d) begin
                    r = r - d;
                    f = f | 64'd1;
                end
            end
            if (f > 64'h7FFF_FFFF)
                f = 64'h7FFF_FFFF;
        end
        return ((num < 0) != (den < 0)) ? -longint'(f) : longint'(f);
    endfunction

    function automatic t_estimate filter_step(t_sample s);
        longint    meas, rate, dt, qa, rm, p00, p01, p10, p11;
        longint    ang, t, inner, sum, k0, k1, innov;
        t_estimate e;
        meas = s.meas;
        rate = s.rate;
        dt = longint'(s.dt);
        qa = longint'(q_angle) << 8;
        rm = longint'(r_meas) << 8;
        p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
        rate = rate - est_bias;
        ang = sat_to(est_angle + mul_round(dt, rate, 16), 32);
        t = mul_round(dt, p11, 16);
        inner = t - p01 - p10 + qa;
        p00 = sat_to(p00 + mul_round(dt, inner, 16), 48);
        p01 = sat_to(p01 - t, 48);
        p10 = sat_to(p10 - t, 48);
        p11 = sat_to(p11 + mul_round(longint'(q_bias), dt, 8), 48);
        sum = p00 + rm;
        k0 = kalman_gain(p00, sum);
        k1 = kalman_gain(p10, sum);
        innov = meas - ang;
        est_angle = sat_to(ang + mul_round(k0, innov, 30), 32);
        est_bias = sat_to(est_bias + mul_round(k1, innov, 30), 32);
        cov[0] = sat_to(p00 - mul_round(k0, p00, 30), 48);
        cov[1] = sat_to(p01 - mul_round(k0, p01, 30), 48);
        cov[2] = sat_to(p10 - mul_round(k1, p00, 30), 48);
        cov[3] = sat_to(p11 - mul_round(k1, p01, 30), 48);
        e.ang = est_angle[31:0];
        e.bias = est_bias[31:0];
        return e;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // request driver
    int      tx_gap = 0;
    t_sample cur;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                expected_estimates.push_back(filter_step(cur));
                samples_sent++;
            end
            if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                cur = pending_samples.pop_front();
                i_measured_angle <= cur.meas;
                i_gyro_rate <= cur.rate;
                i_time_step <= cur.dt;
                i_valid <= 1'b1;
                tx_gap = tx_quiet ? 0 : pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result monitor
    int        rx_gap = 0;
    int        rx_long_left = 0;
    bit        rx_long_done = 0;
    t_estimate want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_estimates.size() == 0) begin
                    $error("unexpected result angle=%0d bias=%0d",
                           o_filtered_angle, o_bias_estimate);
                    mismatches++;
                end else begin
                    want = expected_estimates.pop_front();
                    if (o_filtered_angle !== want.ang) begin
                        $error("filtered_angle expected %0d got %0d",
                               want.ang, o_filtered_angle);
                        mismatches++;
                    end
                    if (o_bias_estimate !== want.bias) begin
                        $error("bias_estimate expected %0d got %0d",
                               want.bias, o_bias_estimate);
                        mismatches++;
                    end
                end
            end
            if (rx_long_stall_req && !rx_long_done) begin
                rx_long_done = 1;
                rx_long_left = 3000;
            end
            if (rx_long_left > 0) begin
                rx_long_left--;
                i_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                rx_gap = rx_quiet ? 0 : pick_gap();
            end
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [W_NOISE-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {8'hA5, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ANGLE_Q: q_angle = val;
            REG_BIAS_Q:  q_bias = val;
            REG_MEAS_R:  r_meas = val;
            default: ;
        endcase
    endtask

    task automatic set_noise(input logic [W_NOISE-1:0] qa, qb, r);
        reg_write(REG_ANGLE_Q, qa);
        reg_write(REG_BIAS_Q, qb);
        reg_write(REG_MEAS_R, r);
    endtask

    task automatic add_sample(input logic [W_MEAS-1:0] m, input logic [W_RATE-1:0] g,
                              input logic [W_DT-1:0] d);
        t_sample s;
        s.meas = m;
        s.rate = g;
        s.dt = d;
        pending_samples.push_back(s);
    endtask

    // settled values only: checked away from the driving edge
    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (pending_samples.size() != 0 || i_valid || expected_estimates.size() != 0);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic add_random(input int n);
        logic [W_MEAS-1:0] m;
        logic [W_RATE-1:0] g;
        logic [W_DT-1:0]   d;
        int                sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 9);
            m = (sel == 0) ? W_MEAS'($urandom)
                           : W_MEAS'(int'($urandom_range(0, 23592960)) - 11796480);
            g = (sel == 1) ? $urandom
                           : W_RATE'(int'($urandom_range(0, 26214400)) - 13107200);
            d = (sel == 2) ? W_DT'($urandom) : W_DT'($urandom_range(0, 700));
            add_sample(m, g, d);
        end
    endtask

    initial begin
        q_angle = RST_ANGLE_Q;
        q_bias = RST_BIAS_Q;
        r_meas = RST_MEAS_R;
        est_angle = 0;
        est_bias = 0;
        foreach (cov[i]) cov[i] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all noise zero: innovation variance stays zero, gains zero
        set_noise('0, '0, '0);
        add_sample(25'sd11796480, 32'sd65536, 16'd0);
        add_sample(-25'sd11796480, -32'sd65536, 16'd655);
        add_sample(25'sd1000, 32'sd0, 16'hFFFF);
        drain();

        // defaults plus an ignored address
        set_noise(RST_ANGLE_Q, RST_BIAS_Q, RST_MEAS_R);
        reg_write(2'd3, 24'h123456);
        add_sample(25'sd11796480, 32'h7FFF_FFFF, 16'hFFFF);
        add_sample(-25'sd11796480, 32'h8000_0000, 16'hFFFF);
        add_sample(25'h0FF_FFFF, 32'sd0, 16'd1);
        add_sample(25'h100_0000, -32'sd1, 16'd66);
        add_sample(25'h1FF_FFFF, 32'sd655360, 16'd66);
        add_sample(25'sd0, 32'h7FFF_FFFF, 16'd0);
        add_sample(25'sd5898240, -32'sd6553600, 16'd6553);
        add_sample(25'sd0, 32'sd0, 16'd32768);
        drain();

        // maximum noise
        set_noise(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        add_sample(25'sd11796480, 32'h8000_0000, 16'hFFFF);
        add_sample(-25'sd11796480, 32'h7FFF_FFFF, 16'hFFFF);
        add_random(4);
        drain();

        // small R: gains near and above one
        set_noise(24'hFF_FFFF, 24'hFF_FFFF, 24'd1);
        add_random(100);
        drain();

        // back-pressure: long receiver stall while requests keep coming
        rx_long_stall_req = 1;
        set_noise(RST_ANGLE_Q, RST_BIAS_Q, RST_MEAS_R);
        add_random(150);
        drain();

        tx_quiet = 1;
        rx_quiet = 1;
        set_noise(24'($urandom), 24'($urandom), 24'($urandom));
        add_random(150);
        drain();

        tx_quiet = 0;
        rx_quiet = 0;
        set_noise('0, 24'($urandom), 24'd0);
        add_random(100);
        drain();

        set_noise(24'($urandom), '0, 24'hFF_FFFF);
        add_random(100);
        drain();

        $display("covered %0d requests, %0d results, 8 noise settings incl. zero and max",
                 samples_sent, results_seen);
        if (mismatches == 0 && expected_estimates.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("FAILURE");
        $finish;
    end

endmodule
